>>> hw/rtl/apfa_pkg.sv
// Shared codes and the sequencer state type of the page frame allocator.
package apfa_pkg;

   // Command codes.
   localparam logic [2:0] CMD_ADD_RANGE = 3'd0;
   localparam logic [2:0] CMD_RESERVE   = 3'd1;
   localparam logic [2:0] CMD_REASSIGN  = 3'd2;
   localparam logic [2:0] CMD_ALLOCATE  = 3'd3;
   localparam logic [2:0] CMD_FREE      = 3'd4;
   localparam logic [2:0] CMD_QUERY     = 3'd5;

   // Status codes.
   localparam logic [2:0] ST_OK       = 3'd0;
   localparam logic [2:0] ST_INVALID  = 3'd1;
   localparam logic [2:0] ST_NOMEM    = 3'd2;
   localparam logic [2:0] ST_BOUNDS   = 3'd3;
   localparam logic [2:0] ST_INUSE    = 3'd4;
   localparam logic [2:0] ST_BADSTATE = 3'd5;
   localparam logic [2:0] ST_CONFLICT = 3'd6;
   localparam logic [2:0] ST_FULL     = 3'd7;

   // Page states.
   localparam logic [1:0] PG_FREE      = 2'd0;
   localparam logic [1:0] PG_RESERVED  = 2'd1;
   localparam logic [1:0] PG_ALLOCATED = 2'd2;

   // Configuration register indexes.
   localparam logic [2:0] CSR_FIRST_LOW   = 3'd0;
   localparam logic [2:0] CSR_FIRST_HIGH  = 3'd1;
   localparam logic [2:0] CSR_SECOND_LOW  = 3'd2;
   localparam logic [2:0] CSR_SECOND_HIGH = 3'd3;
   localparam logic [2:0] CSR_ZERO_GUARD  = 3'd4;

   typedef enum logic [9:0] {
      S_IDLE  = 10'b00_0000_0001,
      S_CHECK = 10'b00_0000_0010,
      S_RD    = 10'b00_0000_0100,
      S_EV1   = 10'b00_0000_1000,
      S_EV2   = 10'b00_0001_0000,
      S_CAND  = 10'b00_0010_0000,
      S_CHK   = 10'b00_0100_0000,
      S_WR    = 10'b00_1000_0000,
      S_FIN   = 10'b01_0000_0000,
      S_DONE  = 10'b10_0000_0000
   } state_type;

endpackage

>>> hw/rtl/aligned_page_frame_allocator_core.sv
// Page frame allocator: range table, page metadata store and command sequencer.
//
//  channel | signals                              | transfer when
//  req     | req_valid/req_ready + 8 fields        | req_valid & req_ready
//  rsp     | rsp_valid/rsp_ready + 7 fields        | rsp_valid & rsp_ready
//  csr     | csr_write_en, csr_index, csr_write_data | csr_write_en
//
// One command at a time. Range lookup visits the range entries in order, each
// through a table read, a subtract and a compare; page checks and page writes
// each walk the metadata memory one entry per cycle, and an allocate repeats the
// page check for each aligned candidate tried. Synchronous reset clears counters
// and control; the metadata and range memories need no clearing. A finished
// result waits in the output register while the next command is accepted.
module aligned_page_frame_allocator_core #(
   parameter int PAGE_CAPACITY = 4096,
   parameter int MAX_RANGES    = 16,
   parameter int PAGE_SHIFT    = 12
) (
   input  logic        clock,
   input  logic        reset,
   input  logic        req_valid,
   output logic        req_ready,
   input  logic [2:0]  req_command,
   input  logic [63:0] req_address,
   input  logic [12:0] req_num_pages,
   input  logic [12:0] req_alignment_pages,
   input  logic [63:0] req_limit_address,
   input  logic [7:0]  req_owner,
   input  logic [7:0]  req_new_owner,
   input  logic [2:0]  req_range_kind,
   output logic        rsp_valid,
   input  logic        rsp_ready,
   output logic [2:0]  rsp_status,
   output logic [63:0] rsp_result_address,
   output logic [1:0]  rsp_page_state,
   output logic [7:0]  rsp_page_owner,
   output logic [12:0] rsp_free_pages,
   output logic [12:0] rsp_reserved_pages,
   output logic [12:0] rsp_allocated_pages,
   input  logic        csr_write_en,
   input  logic [2:0]  csr_index,
   input  logic [7:0]  csr_write_data
);
   import apfa_pkg::*;

   localparam int CW  = $clog2(PAGE_CAPACITY + 1);
   localparam int MI  = $clog2(PAGE_CAPACITY);
   localparam int XW  = ((CW > 13) ? CW : 13) + 1;
   localparam int RTW = $clog2(MAX_RANGES + 1);
   localparam int RI  = (MAX_RANGES > 1) ? $clog2(MAX_RANGES) : 1;
   localparam int PGW = 64 - PAGE_SHIFT;
   localparam int RW  = PGW + CW + 3;
   localparam logic [63:0] PMASK = (64'd1 << PAGE_SHIFT) - 64'd1;

   state_type state_ff, state_in;

   logic [2:0]  cmd_ff, cmd_in;
   logic [63:0] addr_ff, addr_in;
   logic [12:0] cnt_ff, cnt_in;
   logic [12:0] align_ff, align_in;
   logic [63:0] limit_ff, limit_in;
   logic [7:0]  owner_ff, owner_in;
   logic [7:0]  nowner_ff, nowner_in;
   logic [2:0]  kind_ff, kind_in;

   logic [7:0] f_lo_ff, f_hi_ff, s_lo_ff, s_hi_ff, zg_ff;

   logic [RTW-1:0] rt_ff, rt_in;
   logic [CW-1:0]  managed_ff, managed_in;
   logic [CW-1:0]  free_ff, free_in;
   logic [CW-1:0]  resv_ff, resv_in;
   logic [CW-1:0]  alloc_ff, alloc_in;

   logic [PGW-1:0] last_base_ff, last_base_in;
   logic [CW-1:0]  last_len_ff, last_len_in;
   logic [63:0]    last_end_ff, last_end_in;
   logic [2:0]     last_kind_ff, last_kind_in;
   logic           merge_ff, merge_in;

   logic [RTW-1:0] scan_ff, scan_in;
   logic [CW-1:0]  start_ff, start_in;
   logic [63:0]    diff_ff, diff_in;
   logic           ge_ff, ge_in;
   logic [63:0]    rs_ff, rs_in;
   logic [63:0]    cand_ff, cand_in;
   logic [XW-1:0]  off_ff, off_in;

   logic [CW-1:0] base_idx_ff, base_idx_in;
   logic [CW-1:0] wlen_ff, wlen_in;
   logic [CW-1:0] rd_cnt_ff, rd_cnt_in;
   logic [CW-1:0] chk_cnt_ff, chk_cnt_in;
   logic          chk_vld_ff, chk_vld_in;
   logic          bad_ff, bad_in;
   logic [CW-1:0] wr_cnt_ff, wr_cnt_in;
   logic [1:0]    qstate_ff, qstate_in;
   logic [7:0]    qowner_ff, qowner_in;
   logic [2:0]    status_ff, status_in;

   logic        rsp_valid_ff, rsp_valid_in;
   logic [2:0]  rsp_status_ff, rsp_status_in;
   logic [63:0] rsp_addr_ff, rsp_addr_in;
   logic [1:0]  rsp_pstate_ff, rsp_pstate_in;
   logic [7:0]  rsp_powner_ff, rsp_powner_in;
   logic [12:0] rsp_free_ff, rsp_free_in;
   logic [12:0] rsp_resv_ff, rsp_resv_in;
   logic [12:0] rsp_alloc_ff, rsp_alloc_in;

   // Page metadata memory: owner in bits 9:2, state in bits 1:0.
   logic [9:0]    meta_mem [PAGE_CAPACITY];
   logic [9:0]    meta_rd_ff;
   logic          meta_we;
   logic [MI-1:0] meta_waddr, meta_raddr;
   logic [9:0]    meta_wdata;
   logic [CW-1:0] meta_wsum, meta_rsum;

   // Range table memory: base page, length, kind.
   logic [RW-1:0] rng_mem [MAX_RANGES];
   logic [RW-1:0] rng_rd_ff;
   logic          rng_we;
   logic [RI-1:0] rng_waddr;
   logic [RW-1:0] rng_wdata;

   logic [PGW-1:0] rd_base;
   logic [CW-1:0]  rd_len;
   logic [2:0]     rd_kind;

   logic [63:0] size_w, rb_w, first_w, cand_w, cbase_w, end_w;
   logic [12:0] mask13;
   logic        misal, ovf, own_ok, reg_hit, qry_hit, fit, lim_bad, pow2;
   logic [1:0]  m_state;
   logic [7:0]  m_owner;

   assign rd_base = rng_rd_ff[RW-1 -: PGW];
   assign rd_len  = rng_rd_ff[3 +: CW];
   assign rd_kind = rng_rd_ff[2:0];

   assign size_w  = 64'(cnt_ff) << PAGE_SHIFT;
   assign end_w   = addr_ff + size_w;
   assign misal   = (addr_ff & PMASK) != 64'd0;
   assign ovf     = addr_ff > ~size_w;
   assign own_ok  = (owner_ff >= f_lo_ff && owner_ff <= f_hi_ff) ||
                    (owner_ff >= s_lo_ff && owner_ff <= s_hi_ff);
   assign mask13  = align_ff - 13'd1;
   assign pow2    = (align_ff != 13'd0) && ((align_ff & mask13) == 13'd0);
   assign rb_w    = 64'(rd_base) << PAGE_SHIFT;
   assign first_w = 64'(rd_base);
   assign cand_w  = (first_w + 64'(mask13)) & ~64'(mask13);
   assign cbase_w = cand_ff << PAGE_SHIFT;
   assign reg_hit = ge_ff && (diff_ff <= rs_ff) && (size_w <= rs_ff - diff_ff);
   assign qry_hit = ge_ff && (diff_ff < rs_ff);
   assign fit     = (off_ff < XW'(rd_len)) && (XW'(cnt_ff) <= XW'(rd_len) - off_ff);
   assign lim_bad = (cbase_w > limit_ff) || ((size_w - 64'd1) > (limit_ff - cbase_w));
   assign m_state = meta_rd_ff[1:0];
   assign m_owner = meta_rd_ff[9:2];

   assign meta_wsum  = base_idx_ff + wr_cnt_ff;
   assign meta_rsum  = base_idx_ff + rd_cnt_ff;
   assign meta_waddr = meta_wsum[MI-1:0];
   assign meta_raddr = meta_rsum[MI-1:0];

   always_comb begin
      unique case (cmd_ff)
         CMD_ADD_RANGE: meta_wdata = (kind_ff == 3'd0) ? {8'd0, PG_FREE}
                                                       : {owner_ff, PG_RESERVED};
         CMD_RESERVE:   meta_wdata = {owner_ff, PG_RESERVED};
         CMD_REASSIGN:  meta_wdata = {nowner_ff, PG_RESERVED};
         CMD_ALLOCATE:  meta_wdata = {owner_ff, PG_ALLOCATED};
         default:       meta_wdata = {8'd0, PG_FREE};
      endcase
   end

   always_comb begin
      state_in     = state_ff;
      cmd_in       = cmd_ff;
      addr_in      = addr_ff;
      cnt_in       = cnt_ff;
      align_in     = align_ff;
      limit_in     = limit_ff;
      owner_in     = owner_ff;
      nowner_in    = nowner_ff;
      kind_in      = kind_ff;
      rt_in        = rt_ff;
      managed_in   = managed_ff;
      free_in      = free_ff;
      resv_in      = resv_ff;
      alloc_in     = alloc_ff;
      last_base_in = last_base_ff;
      last_len_in  = last_len_ff;
      last_end_in  = last_end_ff;
      last_kind_in = last_kind_ff;
      merge_in     = merge_ff;
      scan_in      = scan_ff;
      start_in     = start_ff;
      diff_in      = diff_ff;
      ge_in        = ge_ff;
      rs_in        = rs_ff;
      cand_in      = cand_ff;
      off_in       = off_ff;
      base_idx_in  = base_idx_ff;
      wlen_in      = wlen_ff;
      rd_cnt_in    = rd_cnt_ff;
      chk_cnt_in   = chk_cnt_ff;
      chk_vld_in   = 1'b0;
      bad_in       = bad_ff;
      wr_cnt_in    = wr_cnt_ff;
      qstate_in    = qstate_ff;
      qowner_in    = qowner_ff;
      status_in    = status_ff;
      rsp_valid_in = rsp_valid_ff && !rsp_ready;
      rsp_status_in = rsp_status_ff;
      rsp_addr_in   = rsp_addr_ff;
      rsp_pstate_in = rsp_pstate_ff;
      rsp_powner_in = rsp_powner_ff;
      rsp_free_in   = rsp_free_ff;
      rsp_resv_in   = rsp_resv_ff;
      rsp_alloc_in  = rsp_alloc_ff;
      meta_we   = 1'b0;
      rng_we    = 1'b0;
      rng_waddr = rt_ff[RI-1:0];
      rng_wdata = {addr_ff[63:PAGE_SHIFT], CW'(cnt_ff), kind_ff};

      unique case (state_ff)
         S_IDLE: begin
            if (req_valid) begin
               cmd_in    = req_command;
               addr_in   = req_address;
               cnt_in    = req_num_pages;
               align_in  = req_alignment_pages;
               limit_in  = req_limit_address;
               owner_in  = req_owner;
               nowner_in = req_new_owner;
               kind_in   = req_range_kind;
               state_in  = S_CHECK;
            end
         end
         S_CHECK: begin
            scan_in   = '0;
            start_in  = '0;
            status_in = ST_INVALID;
            state_in  = S_DONE;
            unique case (cmd_ff)
               CMD_ADD_RANGE: begin
                  merge_in = (rt_ff != '0) && (addr_ff == last_end_ff) &&
                             (kind_ff == last_kind_ff);
                  if (cnt_ff == 13'd0 || misal || ovf) begin
                     status_in = ST_INVALID;
                  end else if (rt_ff != '0 && addr_ff < last_end_ff) begin
                     status_in = ST_CONFLICT;
                  end else if (XW'(managed_ff) + XW'(cnt_ff) > XW'(PAGE_CAPACITY)) begin
                     status_in = ST_BOUNDS;
                  end else if (!merge_in && rt_ff >= RTW'(MAX_RANGES)) begin
                     status_in = ST_FULL;
                  end else begin
                     base_idx_in = managed_ff;
                     wlen_in     = CW'(cnt_ff);
                     wr_cnt_in   = '0;
                     state_in    = S_WR;
                  end
               end
               CMD_RESERVE, CMD_REASSIGN, CMD_FREE: begin
                  if ((cmd_ff == CMD_RESERVE && !own_ok && owner_ff != zg_ff) ||
                      (cmd_ff == CMD_FREE && !own_ok) ||
                      (cmd_ff == CMD_REASSIGN &&
                       (owner_ff == 8'd0 || owner_ff > f_hi_ff ||
                        nowner_ff == 8'd0 || nowner_ff > f_hi_ff))) begin
                     status_in = ST_INVALID;
                  end else if (cnt_ff == 13'd0 || misal) begin
                     status_in = ST_INVALID;
                  end else if (ovf) begin
                     status_in = ST_BOUNDS;
                  end else begin
                     state_in = S_RD;
                  end
               end
               CMD_ALLOCATE: begin
                  if (cnt_ff == 13'd0 || !pow2 || !own_ok || limit_ff < PMASK) begin
                     status_in = ST_INVALID;
                  end else if (XW'(cnt_ff) > XW'(free_ff) ||
                               XW'(cnt_ff) > XW'(managed_ff)) begin
                     status_in = ST_NOMEM;
                  end else begin
                     state_in = S_RD;
                  end
               end
               CMD_QUERY: begin
                  state_in = S_RD;
               end
               default: begin
                  status_in = ST_INVALID;
               end
            endcase
         end
         S_RD: begin
            if (scan_ff == rt_ff) begin
               status_in = (cmd_ff == CMD_ALLOCATE) ? ST_NOMEM : ST_BOUNDS;
               state_in  = S_DONE;
            end else begin
               state_in = S_EV1;
            end
         end
         S_EV1: begin
            diff_in = addr_ff - rb_w;
            ge_in   = addr_ff >= rb_w;
            rs_in   = 64'(rd_len) << PAGE_SHIFT;
            if (cmd_ff == CMD_ALLOCATE) begin
               if (rd_kind == 3'd0 && CW'(cnt_ff) <= rd_len &&
                   XW'(cnt_ff) <= XW'(rd_len)) begin
                  cand_in  = cand_w;
                  off_in   = XW'(cand_w - first_w);
                  state_in = S_CAND;
               end else begin
                  start_in = start_ff + rd_len;
                  scan_in  = scan_ff + RTW'(1);
                  state_in = S_RD;
               end
            end else begin
               state_in = S_EV2;
            end
         end
         S_EV2: begin
            if ((cmd_ff == CMD_QUERY) ? qry_hit : reg_hit) begin
               base_idx_in = start_ff + CW'(diff_ff >> PAGE_SHIFT);
               wlen_in     = (cmd_ff == CMD_QUERY) ? CW'(1) : CW'(cnt_ff);
               rd_cnt_in   = '0;
               chk_cnt_in  = '0;
               bad_in      = 1'b0;
               state_in    = S_CHK;
            end else begin
               start_in = start_ff + rd_len;
               scan_in  = scan_ff + RTW'(1);
               state_in = S_RD;
            end
         end
         S_CAND: begin
            if (!fit || lim_bad) begin
               start_in = start_ff + rd_len;
               scan_in  = scan_ff + RTW'(1);
               state_in = S_RD;
            end else begin
               base_idx_in = CW'(XW'(start_ff) + off_ff);
               wlen_in     = CW'(cnt_ff);
               rd_cnt_in   = '0;
               chk_cnt_in  = '0;
               bad_in      = 1'b0;
               state_in    = S_CHK;
            end
         end
         S_CHK: begin
            // Reads are issued one per cycle; each result is checked in the next cycle.
            if (rd_cnt_ff != wlen_ff) begin
               rd_cnt_in  = rd_cnt_ff + CW'(1);
               chk_vld_in = 1'b1;
            end
            if (chk_vld_ff) begin
               chk_cnt_in = chk_cnt_ff + CW'(1);
               unique case (cmd_ff)
                  CMD_RESERVE, CMD_ALLOCATE: begin
                     if (m_state != PG_FREE) begin
                        bad_in = 1'b1;
                     end
                  end
                  CMD_REASSIGN: begin
                     if (m_state != PG_RESERVED || m_owner != owner_ff) begin
                        bad_in = 1'b1;
                     end
                  end
                  CMD_FREE: begin
                     if (m_state != PG_ALLOCATED || m_owner != owner_ff) begin
                        bad_in = 1'b1;
                     end
                  end
                  default: begin
                     qstate_in = m_state;
                     qowner_in = m_owner;
                  end
               endcase
            end
            if (chk_cnt_ff == wlen_ff && !chk_vld_ff) begin
               wr_cnt_in = '0;
               if (cmd_ff == CMD_QUERY) begin
                  status_in = ST_OK;
                  state_in  = S_DONE;
               end else if (!bad_ff) begin
                  state_in = S_WR;
               end else if (cmd_ff == CMD_ALLOCATE) begin
                  off_in   = off_ff + XW'(align_ff);
                  cand_in  = cand_ff + 64'(align_ff);
                  state_in = S_CAND;
               end else begin
                  status_in = (cmd_ff == CMD_RESERVE) ? ST_INUSE : ST_BADSTATE;
                  state_in  = S_DONE;
               end
            end
         end
         S_WR: begin
            meta_we = 1'b1;
            if (wr_cnt_ff == wlen_ff - CW'(1)) begin
               state_in = S_FIN;
            end else begin
               wr_cnt_in = wr_cnt_ff + CW'(1);
            end
         end
         S_FIN: begin
            status_in = ST_OK;
            state_in  = S_DONE;
            unique case (cmd_ff)
               CMD_ADD_RANGE: begin
                  rng_we       = 1'b1;
                  managed_in   = managed_ff + CW'(cnt_ff);
                  last_end_in  = end_w;
                  last_kind_in = kind_ff;
                  if (merge_ff) begin
                     rng_waddr   = RI'(rt_ff - RTW'(1));
                     last_len_in = last_len_ff + CW'(cnt_ff);
                     rng_wdata   = {last_base_ff, last_len_in, kind_ff};
                  end else begin
                     rt_in        = rt_ff + RTW'(1);
                     last_base_in = addr_ff[63:PAGE_SHIFT];
                     last_len_in  = CW'(cnt_ff);
                  end
                  if (kind_ff == 3'd0) begin
                     free_in = free_ff + CW'(cnt_ff);
                  end else begin
                     resv_in = resv_ff + CW'(cnt_ff);
                  end
               end
               CMD_RESERVE: begin
                  free_in = free_ff - CW'(cnt_ff);
                  resv_in = resv_ff + CW'(cnt_ff);
               end
               CMD_ALLOCATE: begin
                  free_in  = free_ff - CW'(cnt_ff);
                  alloc_in = alloc_ff + CW'(cnt_ff);
               end
               CMD_FREE: begin
                  alloc_in = alloc_ff - CW'(cnt_ff);
                  free_in  = free_ff + CW'(cnt_ff);
               end
               default: begin
               end
            endcase
         end
         S_DONE: begin
            if (!rsp_valid_ff || rsp_ready) begin
               rsp_valid_in  = 1'b1;
               rsp_status_in = status_ff;
               rsp_addr_in   = (cmd_ff == CMD_ALLOCATE && status_ff == ST_OK) ?
                               cbase_w : 64'd0;
               rsp_pstate_in = (cmd_ff == CMD_QUERY && status_ff == ST_OK) ?
                               qstate_ff : PG_FREE;
               rsp_powner_in = (cmd_ff == CMD_QUERY && status_ff == ST_OK) ?
                               qowner_ff : 8'd0;
               // The counters are frozen with the result while it waits.
               rsp_free_in   = 13'(free_ff);
               rsp_resv_in   = 13'(resv_ff);
               rsp_alloc_in  = 13'(alloc_ff);
               state_in      = S_IDLE;
            end
         end
         default: begin
            state_in = S_IDLE;
         end
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= S_IDLE;
         rt_ff        <= '0;
         managed_ff   <= '0;
         free_ff      <= '0;
         resv_ff      <= '0;
         alloc_ff     <= '0;
         chk_vld_ff   <= 1'b0;
         rsp_valid_ff <= 1'b0;
         f_lo_ff      <= 8'd6;
         f_hi_ff      <= 8'd9;
         s_lo_ff      <= 8'd16;
         s_hi_ff      <= 8'd20;
         zg_ff        <= 8'd5;
      end else begin
         state_ff     <= state_in;
         rt_ff        <= rt_in;
         managed_ff   <= managed_in;
         free_ff      <= free_in;
         resv_ff      <= resv_in;
         alloc_ff     <= alloc_in;
         chk_vld_ff   <= chk_vld_in;
         rsp_valid_ff <= rsp_valid_in;
         if (csr_write_en) begin
            case (csr_index)
               CSR_FIRST_LOW:   f_lo_ff <= csr_write_data;
               CSR_FIRST_HIGH:  f_hi_ff <= csr_write_data;
               CSR_SECOND_LOW:  s_lo_ff <= csr_write_data;
               CSR_SECOND_HIGH: s_hi_ff <= csr_write_data;
               CSR_ZERO_GUARD:  zg_ff   <= csr_write_data;
               default: begin
               end
            endcase
         end
      end
   end

   always_ff @(posedge clock) begin
      cmd_ff        <= cmd_in;
      addr_ff       <= addr_in;
      cnt_ff        <= cnt_in;
      align_ff      <= align_in;
      limit_ff      <= limit_in;
      owner_ff      <= owner_in;
      nowner_ff     <= nowner_in;
      kind_ff       <= kind_in;
      last_base_ff  <= last_base_in;
      last_len_ff   <= last_len_in;
      last_end_ff   <= last_end_in;
      last_kind_ff  <= last_kind_in;
      merge_ff      <= merge_in;
      scan_ff       <= scan_in;
      start_ff      <= start_in;
      diff_ff       <= diff_in;
      ge_ff         <= ge_in;
      rs_ff         <= rs_in;
      cand_ff       <= cand_in;
      off_ff        <= off_in;
      base_idx_ff   <= base_idx_in;
      wlen_ff       <= wlen_in;
      rd_cnt_ff     <= rd_cnt_in;
      chk_cnt_ff    <= chk_cnt_in;
      bad_ff        <= bad_in;
      wr_cnt_ff     <= wr_cnt_in;
      qstate_ff     <= qstate_in;
      qowner_ff     <= qowner_in;
      status_ff     <= status_in;
      rsp_status_ff <= rsp_status_in;
      rsp_addr_ff   <= rsp_addr_in;
      rsp_pstate_ff <= rsp_pstate_in;
      rsp_powner_ff <= rsp_powner_in;
      rsp_free_ff   <= rsp_free_in;
      rsp_resv_ff   <= rsp_resv_in;
      rsp_alloc_ff  <= rsp_alloc_in;
   end

   always_ff @(posedge clock) begin
      if (meta_we) begin
         meta_mem[meta_waddr] <= meta_wdata;
      end
      meta_rd_ff <= meta_mem[meta_raddr];
   end

   always_ff @(posedge clock) begin
      if (rng_we) begin
         rng_mem[rng_waddr] <= rng_wdata;
      end
      rng_rd_ff <= rng_mem[scan_ff[RI-1:0]];
   end

   assign req_ready           = (state_ff == S_IDLE);
   assign rsp_valid           = rsp_valid_ff;
   assign rsp_status          = rsp_status_ff;
   assign rsp_result_address  = rsp_addr_ff;
   assign rsp_page_state      = rsp_pstate_ff;
   assign rsp_page_owner      = rsp_powner_ff;
   assign rsp_free_pages      = rsp_free_ff;
   assign rsp_reserved_pages  = rsp_resv_ff;
   assign rsp_allocated_pages = rsp_alloc_ff;

   // Every managed page is counted in exactly one of the three counters.
   a_counters_sum: assert property (@(posedge clock) disable iff (reset)
      (XW'(free_ff) + XW'(resv_ff) + XW'(alloc_ff)) == XW'(managed_ff))
      else $error("page counters do not add up to the managed total");

   a_range_total: assert property (@(posedge clock) disable iff (reset)
      rt_ff <= RTW'(MAX_RANGES))
      else $error("range count above table size");

   // Commands other than add_range only rewrite pages that are already managed.
   a_write_inside: assert property (@(posedge clock) disable iff (reset)
      (meta_we && cmd_ff != CMD_ADD_RANGE) |-> (meta_wsum < managed_ff))
      else $error("page write outside managed pages");

   a_accept_starts: assert property (@(posedge clock) disable iff (reset)
      (req_valid && req_ready) |=> (state_ff == S_CHECK))
      else $error("accepted command did not start its checks");

endmodule

>>> bench/tb_top.sv
// Self-checking testbench for the aligned page frame allocator core.
`timescale 1ns / 100ps

module tb_top;
   import apfa_pkg::*;

   localparam int          NPAGES     = 4096;
   localparam int          NRANGES    = 16;
   localparam int          PSHIFT     = 12;
   localparam longint      CYCLE_CAP  = 64'd4_000_000_000;
   localparam logic [2:0]  CMD_SPARE6 = 3'd6;
   localparam logic [2:0]  CMD_SPARE7 = 3'd7;
   localparam logic [63:0] ADDR_TOP   = 64'hFFFF_FFFF_FFFF_FFFF;

   typedef struct {
      logic [2:0]  cmd;
      logic [63:0] addr;
      logic [12:0] cnt;
      logic [12:0] align;
      logic [63:0] limit;
      logic [7:0]  owner;
      logic [7:0]  nowner;
      logic [2:0]  kind;
   } command_type;

   typedef struct packed {
      logic [2:0]  status;
      logic [63:0] base;
      logic [1:0]  pstate;
      logic [7:0]  powner;
      logic [12:0] nfree;
      logic [12:0] nres;
      logic [12:0] nalloc;
   } outcome_type;

   typedef struct {
      logic [63:0] base;
      logic [12:0] cnt;
      logic [7:0]  owner;
   } grant_type;

   class page_ledger;
      bit [1:0]    pst[NPAGES];
      bit [7:0]    pown[NPAGES];
      bit [51:0]   rbase[NRANGES];
      int unsigned rlen[NRANGES];
      bit [2:0]    rkind[NRANGES];
      int unsigned nranges, managed, nfree, nres, nalloc;
      bit [7:0]    b1lo = 6, b1hi = 9, b2lo = 16, b2hi = 20, guard = 5;
      outcome_type awaited[$];
      grant_type   grants[$];
      int          mismatches;

      function void set_reg(logic [2:0] idx, logic [7:0] v);
         case (idx)
            CSR_FIRST_LOW:   b1lo = v;
            CSR_FIRST_HIGH:  b1hi = v;
            CSR_SECOND_LOW:  b2lo = v;
            CSR_SECOND_HIGH: b2hi = v;
            CSR_ZERO_GUARD:  guard = v;
            default: ;
         endcase
      endfunction

      function bit owner_ok(bit [7:0] o);
         return (o >= b1lo && o <= b1hi) || (o >= b2lo && o <= b2hi);
      endfunction

      function bit [63:0] span_end(int i);
         return {rbase[i], 12'h000} + (64'(rlen[i]) << PSHIFT);
      endfunction

      function bit [2:0] find_region(bit [63:0] base, bit [63:0] cnt, output int unsigned idx);
         bit [63:0] size, rb, rs, start;
         start = 0;
         idx = 0;
         if (cnt == 0 || base[11:0] != 0) return ST_INVALID;
         size = cnt << PSHIFT;
         if (base > ~size) return ST_BOUNDS;
         for (int i = 0; i < nranges; i++) begin
            rb = {rbase[i], 12'h000};
            rs = 64'(rlen[i]) << PSHIFT;
            if (base >= rb && base - rb <= rs && size <= rs - (base - rb)) begin
               idx = 32'(start + ((base - rb) >> PSHIFT));
               return ST_OK;
            end
            start += rlen[i];
         end
         return ST_BOUNDS;
      endfunction

      function bit [2:0] add_range(command_type c);
         bit [63:0] size, pend;
         bit        merge;
         merge = 0;
         if (c.cnt == 0 || c.addr[11:0] != 0) return ST_INVALID;
         size = 64'(c.cnt) << PSHIFT;
         if (c.addr > ~size) return ST_INVALID;
         if (nranges > 0) begin
            pend = span_end(nranges - 1);
            if (c.addr < pend) return ST_CONFLICT;
            merge = (c.addr == pend && c.kind == rkind[nranges - 1]);
         end
         if (managed + c.cnt > NPAGES) return ST_BOUNDS;
         if (!merge && nranges >= NRANGES) return ST_FULL;
         if (merge) rlen[nranges - 1] += c.cnt;
         else begin
            rbase[nranges] = c.addr[63:12];
            rlen[nranges]  = c.cnt;
            rkind[nranges] = c.kind;
            nranges++;
         end
         for (int k = 0; k < c.cnt; k++) begin
            pst[managed + k]  = (c.kind == 0) ? PG_FREE : PG_RESERVED;
            pown[managed + k] = (c.kind == 0) ? 8'd0 : c.owner;
         end
         managed += c.cnt;
         if (c.kind == 0) nfree += c.cnt;
         else nres += c.cnt;
         return ST_OK;
      endfunction

      function bit [2:0] allocate(command_type c, output bit [63:0] got);
         bit [63:0] start, mask, len, first, cand, off, cbase, asize;
         bit        clear;
         got = 0;
         start = 0;
         if (c.cnt == 0 || c.align == 0 || (c.align & (c.align - 1)) != 0 ||
             !owner_ok(c.owner) || c.limit < (64'd1 << PSHIFT) - 64'd1)
            return ST_INVALID;
         if (c.cnt > nfree || c.cnt > managed) return ST_NOMEM;
         mask = 64'(c.align) - 1;
         for (int i = 0; i < nranges; i++) begin
            len   = rlen[i];
            first = 64'(rbase[i]);
            if (rkind[i] == 0 && c.cnt <= len && first <= ~mask) begin
               cand = (first + mask) & ~mask;
               off  = cand - first;
               while (off < len && c.cnt <= len - off) begin
                  cbase = cand << PSHIFT;
                  asize = 64'(c.cnt) << PSHIFT;
                  if (cbase > c.limit || asize - 1 > c.limit - cbase) break;
                  clear = 1;
                  for (int k = 0; k < c.cnt; k++)
                     if (pst[start + off + k] != PG_FREE) clear = 0;
                  if (clear) begin
                     for (int k = 0; k < c.cnt; k++) begin
                        pst[start + off + k]  = PG_ALLOCATED;
                        pown[start + off + k] = c.owner;
                     end
                     nfree  -= c.cnt;
                     nalloc += c.cnt;
                     got = cbase;
                     grants.push_back('{cbase, c.cnt, c.owner});
                     return ST_OK;
                  end
                  off  += c.align;
                  cand += c.align;
               end
            end
            start += len;
         end
         return ST_NOMEM;
      endfunction

      // Works out the result of one accepted command and queues it.
      function void note_command(command_type c);
         outcome_type o;
         int unsigned idx;
         bit [63:0]   start, rb;
         o = '{default: 0};
         o.status = ST_INVALID;
         case (c.cmd)
            CMD_ADD_RANGE: o.status = add_range(c);
            CMD_RESERVE: begin
               if (owner_ok(c.owner) || c.owner == guard) begin
                  o.status = find_region(c.addr, c.cnt, idx);
                  if (o.status == ST_OK) begin
                     for (int k = 0; k < c.cnt; k++)
                        if (pst[idx + k] != PG_FREE) o.status = ST_INUSE;
                     if (o.status == ST_OK) begin
                        for (int k = 0; k < c.cnt; k++) begin
                           pst[idx + k]  = PG_RESERVED;
                           pown[idx + k] = c.owner;
                        end
                        nfree -= c.cnt;
                        nres  += c.cnt;
                     end
                  end
               end
            end
            CMD_REASSIGN: begin
               if (c.owner != 0 && c.owner <= b1hi && c.nowner != 0 && c.nowner <= b1hi) begin
                  o.status = find_region(c.addr, c.cnt, idx);
                  if (o.status == ST_OK) begin
                     for (int k = 0; k < c.cnt; k++)
                        if (pst[idx + k] != PG_RESERVED || pown[idx + k] != c.owner)
                           o.status = ST_BADSTATE;
                     if (o.status == ST_OK)
                        for (int k = 0; k < c.cnt; k++) pown[idx + k] = c.nowner;
                  end
               end
            end
            CMD_ALLOCATE: o.status = allocate(c, o.base);
            CMD_FREE: begin
               if (owner_ok(c.owner)) begin
                  o.status = find_region(c.addr, c.cnt, idx);
                  if (o.status == ST_OK) begin
                     for (int k = 0; k < c.cnt; k++)
                        if (pst[idx + k] != PG_ALLOCATED || pown[idx + k] != c.owner)
                           o.status = ST_BADSTATE;
                     if (o.status == ST_OK) begin
                        for (int k = 0; k < c.cnt; k++) begin
                           pst[idx + k]  = PG_FREE;
                           pown[idx + k] = 0;
                        end
                        nalloc -= c.cnt;
                        nfree  += c.cnt;
                     end
                  end
               end
            end
            CMD_QUERY: begin
               o.status = ST_BOUNDS;
               start = 0;
               for (int i = 0; i < nranges; i++) begin
                  rb = {rbase[i], 12'h000};
                  if (o.status == ST_BOUNDS && c.addr >= rb &&
                      c.addr - rb < (64'(rlen[i]) << PSHIFT)) begin
                     idx      = 32'(start + ((c.addr - rb) >> PSHIFT));
                     o.status = ST_OK;
                     o.pstate = pst[idx];
                     o.powner = pown[idx];
                  end
                  start += rlen[i];
               end
            end
            default: o.status = ST_INVALID;
         endcase
         o.nfree  = 13'(nfree);
         o.nres   = 13'(nres);
         o.nalloc = 13'(nalloc);
         awaited.push_back(o);
      endfunction

      function void check_result(outcome_type got);
         outcome_type want;
         if (awaited.size() == 0) begin
            mismatches++;
            if (mismatches <= 10) $display("unexpected result: status %0d", got.status);
            return;
         end
         want = awaited.pop_front();
         if (got != want) begin
            mismatches++;
            if (mismatches <= 10) begin
               $write("mismatch: expected st=%0d base=%h ps=%0d po=%0d f/r/a=%0d/%0d/%0d, ",
                      want.status, want.base, want.pstate, want.powner, want.nfree,
                      want.nres, want.nalloc);
               $display("got st=%0d base=%h ps=%0d po=%0d f/r/a=%0d/%0d/%0d",
                        got.status, got.base, got.pstate, got.powner, got.nfree,
                        got.nres, got.nalloc);
            end
         end
      endfunction
   endclass

   logic        clock = 0;
   logic        reset = 1;
   logic        req_valid = 0, req_ready;
   logic [2:0]  req_command = '0;
   logic [63:0] req_address = '0, req_limit_address = '0;
   logic [12:0] req_num_pages = '0, req_alignment_pages = '0;
   logic [7:0]  req_owner = '0, req_new_owner = '0;
   logic [2:0]  req_range_kind = '0;
   logic        rsp_valid, rsp_ready = 0;
   logic [2:0]  rsp_status;
   logic [63:0] rsp_result_address;
   logic [1:0]  rsp_page_state;
   logic [7:0]  rsp_page_owner;
   logic [12:0] rsp_free_pages, rsp_reserved_pages, rsp_allocated_pages;
   logic        csr_write_en = 0;
   logic [2:0]  csr_index = '0;
   logic [7:0]  csr_write_data = '0;

   page_ledger  ledger = new();
   bit          steady;        // no idling on either side
   bit          hold_off_req;  // asks the receiver for one long stall
   longint      cycles = 0;

   aligned_page_frame_allocator_core u_top (.*);

   always begin
      #5 clock = 1;
      #5 clock = 0;
   end

   always @(posedge clock) begin
      cycles <= cycles + 1;
      if (cycles > CYCLE_CAP) begin
         $display("** aligned_page_frame_allocator_core: FAILED **");
         $finish;
      end
   end

   always @(posedge clock)
      if (!reset && rsp_valid && rsp_ready)
         ledger.check_result('{rsp_status, rsp_result_address, rsp_page_state,
                               rsp_page_owner, rsp_free_pages, rsp_reserved_pages,
                               rsp_allocated_pages});

   function automatic int pick_gap();
      return ($urandom_range(0, 19) == 0) ? $urandom_range(20, 80) : $urandom_range(1, 3);
   endfunction

   // Result side: random stalls, plus one long hold-off on request.
   initial begin
      int gap;
      @(negedge reset);
      forever begin
         @(posedge clock);
         if (hold_off_req) begin
            rsp_ready <= 0;
            repeat (600) @(posedge clock);
            hold_off_req = 0;
         end else if (!steady && $urandom_range(0, 4) == 0) begin
            gap = pick_gap();
            rsp_ready <= 0;
            repeat (gap) @(posedge clock);
         end else
            rsp_ready <= 1;
      end
   end

   task automatic send(command_type c);
      int gap;
      req_valid           <= 1;
      req_command         <= c.cmd;
      req_address         <= c.addr;
      req_num_pages       <= c.cnt;
      req_alignment_pages <= c.align;
      req_limit_address   <= c.limit;
      req_owner           <= c.owner;
      req_new_owner       <= c.nowner;
      req_range_kind      <= c.kind;
      do @(posedge clock); while (!req_ready);
      ledger.note_command(c);
      if (!steady && $urandom_range(0, 3) == 0) begin
         gap = pick_gap();
         req_valid <= 0;
         repeat (gap) @(posedge clock);
      end
   endtask

   task automatic drain();
      req_valid <= 0;
      while (ledger.awaited.size() != 0) @(posedge clock);
      repeat (40) @(posedge clock);
   endtask

   task automatic write_regs(logic [7:0] v0, logic [7:0] v1, logic [7:0] v2,
                             logic [7:0] v3, logic [7:0] v4);
      logic [7:0] vals[5];
      vals = '{v0, v1, v2, v3, v4};
      foreach (vals[i]) begin
         csr_write_en   <= 1;
         csr_index      <= 3'(i);
         csr_write_data <= vals[i];
         @(posedge clock);
         ledger.set_reg(3'(i), vals[i]);
      end
      csr_write_en <= 0;
   endtask

   function automatic command_type mk(logic [2:0] cmd, logic [63:0] addr, int cnt, int align,
                                      logic [63:0] limit, int owner, int nowner, int kind);
      return '{cmd, addr, 13'(cnt), 13'(align), limit, 8'(owner), 8'(nowner), 3'(kind)};
   endfunction

   function automatic logic [7:0] band_owner();
      if ($urandom_range(0, 9) == 0) return 8'($urandom);
      if ($urandom_range(0, 1) == 0 && ledger.b1lo <= ledger.b1hi)
         return 8'($urandom_range(ledger.b1lo, ledger.b1hi));
      if (ledger.b2lo <= ledger.b2hi) return 8'($urandom_range(ledger.b2lo, ledger.b2hi));
      return ($urandom_range(0, 1) == 0) ? ledger.guard : 8'($urandom);
   endfunction

   function automatic logic [63:0] rand64();
      return {$urandom, $urandom};
   endfunction

   // Builds one random command, mostly well formed against the current ranges.
   function automatic command_type random_command();
      command_type c;
      int          pick, i, off;
      grant_type   g;
      c = mk(CMD_QUERY, 0, $urandom_range(1, 4), 1, ADDR_TOP, band_owner(),
             band_owner(), 0);
      if (ledger.nranges > 0) begin
         i = $urandom_range(0, ledger.nranges - 1);
         off = $urandom_range(0, ledger.rlen[i] - 1);
         c.addr = {ledger.rbase[i], 12'h000} + (64'(off) << PSHIFT);
      end else
         c.addr = rand64() & ~64'hFFF;
      pick = $urandom_range(0, 99);
      if (pick < 12) begin
         c.cmd = CMD_ADD_RANGE;
         c.cnt = 13'(($urandom_range(0, 7) == 0) ? $urandom_range(65, 700)
                                                 : $urandom_range(1, 64));
         c.kind = 3'(($urandom_range(0, 2) == 0) ? $urandom_range(1, 7) : 0);
         c.owner = 8'($urandom);
         c.addr = (ledger.nranges > 0) ? ledger.span_end(ledger.nranges - 1) : 64'h10_0000;
         c.addr += 64'($urandom_range(0, 1) ? 0 : $urandom_range(1, 300)) << PSHIFT;
      end else if (pick < 40) begin
         c.cmd = CMD_ALLOCATE;
         c.cnt = 13'(($urandom_range(0, 9) == 0) ? $urandom_range(9, 96)
                                                 : $urandom_range(1, 8));
         c.align = 13'(1) << (($urandom_range(0, 3) == 0) ? $urandom_range(0, 12)
                                                          : $urandom_range(0, 3));
         if ($urandom_range(0, 3) == 0) c.limit = rand64() >> $urandom_range(0, 40);
      end else if (pick < 55) begin
         c.cmd = CMD_FREE;
         if (ledger.grants.size() > 0) begin
            i = $urandom_range(0, ledger.grants.size() - 1);
            g = ledger.grants[i];
            ledger.grants.delete(i);
            c.addr = g.base;
            c.cnt = g.cnt;
            c.owner = g.owner;
            if ($urandom_range(0, 7) == 0) c.owner = band_owner();
         end
      end else if (pick < 68) begin
         c.cmd = CMD_RESERVE;
         if ($urandom_range(0, 2) == 0) c.owner = ledger.guard;
      end else if (pick < 78) begin
         c.cmd = CMD_REASSIGN;
         c.owner = 8'($urandom_range(0, 10));
         c.nowner = 8'($urandom_range(1, 10));
      end else if (pick < 86) begin
         c.cmd = CMD_QUERY;
         c.addr += 64'($urandom_range(0, 4095));
      end else
         c = '{3'($urandom), rand64(), 13'($urandom), 13'($urandom), rand64(),
               8'($urandom), 8'($urandom), 3'($urandom)};
      return c;
   endfunction

   initial begin
      repeat (4) @(posedge clock);
      reset <= 0;
      @(posedge clock);

      // Nothing managed yet.
      send(mk(CMD_QUERY, 64'h1000, 0, 0, 0, 0, 0, 0));
      send(mk(CMD_ALLOCATE, 0, 1, 1, ADDR_TOP, 6, 0, 0));
      send(mk(CMD_RESERVE, 64'h1000, 1, 0, 0, 6, 0, 0));
      // Range table: good, bad, overlapping, merged and reserved-kind ranges.
      send(mk(CMD_ADD_RANGE, 64'h10_0000, 64, 0, 0, 0, 0, 0));
      send(mk(CMD_ADD_RANGE, 64'h20_0000, 0, 0, 0, 0, 0, 0));
      send(mk(CMD_ADD_RANGE, 64'h20_0800, 4, 0, 0, 0, 0, 0));
      send(mk(CMD_ADD_RANGE, 64'hFFFF_FFFF_FFFF_F000, 2, 0, 0, 0, 0, 0));
      send(mk(CMD_ADD_RANGE, 64'h10_0000, 4, 0, 0, 0, 0, 0));
      send(mk(CMD_ADD_RANGE, 64'h14_0000, 16, 0, 0, 0, 0, 0));
      send(mk(CMD_ADD_RANGE, 64'h20_0000, 16, 0, 0, 7, 0, 7));
      send(mk(CMD_ADD_RANGE, 64'h40_0000, 4096, 0, 0, 0, 0, 0));
      // Allocation arguments, limits and success.
      send(mk(CMD_ALLOCATE, 0, 4, 4, ADDR_TOP, 6, 0, 0));
      send(mk(CMD_ALLOCATE, 0, 2, 3, ADDR_TOP, 6, 0, 0));
      send(mk(CMD_ALLOCATE, 0, 2, 0, ADDR_TOP, 6, 0, 0));
      send(mk(CMD_ALLOCATE, 0, 1, 1, 64'hFFE, 6, 0, 0));
      send(mk(CMD_ALLOCATE, 0, 1, 1, 64'h10_0FFF, 0, 0, 0));
      send(mk(CMD_ALLOCATE, 0, 8191, 1, ADDR_TOP, 20, 0, 0));
      send(mk(CMD_ALLOCATE, 0, 16, 4096, ADDR_TOP, 16, 0, 0));
      // Reserve, reassign, free and query.
      send(mk(CMD_RESERVE, 64'h10_8000, 2, 0, 0, 5, 0, 0));
      send(mk(CMD_RESERVE, 64'h10_8000, 1, 0, 0, 9, 0, 0));
      send(mk(CMD_RESERVE, 64'hFFFF_FFFF_FFFF_F000, 2, 0, 0, 0, 0, 0));
      send(mk(CMD_REASSIGN, 64'h20_0000, 16, 0, 0, 7, 8, 0));
      send(mk(CMD_REASSIGN, 64'h20_0000, 1, 0, 0, 7, 9, 0));
      send(mk(CMD_FREE, 64'h10_0000, 4, 0, 0, 6, 0, 0));
      send(mk(CMD_QUERY, 64'h20_0FFF, 0, 0, 0, 0, 0, 0));
      send(mk(CMD_SPARE6, 0, 0, 0, 0, 0, 0, 0));
      send(mk(CMD_SPARE7, ADDR_TOP, 8191, 8191, ADDR_TOP, 255, 255, 7));

      // Random phases, each under its own register setting.
      for (int phase = 0; phase < 4; phase++) begin
         drain();
         case (phase)
            1: write_regs(8'd0, 8'd255, 8'd255, 8'd0, 8'd0);
            2: write_regs(8'd255, 8'd255, 8'd1, 8'd3, 8'd255);
            3: write_regs(8'd6, 8'd10, 8'd16, 8'd40, 8'd5);
            default: ;
         endcase
         steady = (phase == 2);
         for (int n = 0; n < 35; n++) begin
            // Long receiver stall while commands keep coming.
            if (phase == 1 && n == 5) hold_off_req = 1;
            // Sender waits for every outstanding result once.
            if (phase == 3 && n == 15) begin
               req_valid <= 0;
               while (ledger.awaited.size() != 0) @(posedge clock);
            end
            send(random_command());
         end
      end

      drain();
      if (ledger.mismatches == 0)
         $display("** aligned_page_frame_allocator_core: PASSED **");
      else
         $display("** aligned_page_frame_allocator_core: FAILED **");
      $finish;
   end

endmodule
